[rtl/nppr_pkg.sv]
package nppr_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] CFG_NOISE_SD    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRIOR_MEAN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRIOR_SD    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OBS_SUM     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OBS_COUNT   = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_MUL,
        OP_NUM,
        OP_ZERO_DEN,
        OP_DIV_MEAN,
        OP_MEAN_FIX,
        OP_DIV_VAR,
        OP_SQRT,
        OP_SD_FIX,
        OP_DRAW,
        OP_ACCUM,
        OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        MS_NN2,
        MS_PP2,
        MS_DEN,
        MS_T1,
        MS_T2,
        MS_VNUM,
        MS_DRAW
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic den_zero;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NN2,
        ST_PP2,
        ST_DEN,
        ST_T1,
        ST_T2,
        ST_NUM,
        ST_ZD,
        ST_DIVM,
        ST_MFIX,
        ST_VMUL,
        ST_DIVV,
        ST_SQRT,
        ST_SDFIX,
        ST_DMUL,
        ST_DRAW,
        ST_ACCUM,
        ST_OUT
    } ctrl_state_t;

endpackage

[rtl/nppr_ctrl.sv]
module nppr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                start_chain,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output nppr_pkg::dp_cmd_t   cmd,
    input  nppr_pkg::dp_status_t status
);
    import nppr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        after_start_reg, after_start_next;
    logic        out_valid_reg, out_valid_next;
    ctrl_state_t ret_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            after_start_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            after_start_reg <= after_start_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // The posterior update runs once after a chain restart and once after the draw.
    assign ret_state = after_start_reg ? ST_DMUL : ST_OUT;

    always_comb
    begin
        state_next       = state_reg;
        after_start_next = after_start_reg;
        cmd.op           = OP_NONE;
        cmd.sel          = MS_NN2;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op           = OP_ACCEPT;
                    after_start_next = start_chain;
                    state_next       = start_chain ? ST_LOAD : ST_DMUL;
                end
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = ST_NN2;
            end
            ST_NN2:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MS_NN2;
                if (status.mul_done)
                    state_next = ST_PP2;
            end
            ST_PP2:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MS_PP2;
                if (status.mul_done)
                    state_next = ST_DEN;
            end
            ST_DEN:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MS_DEN;
                if (status.mul_done)
                    state_next = ST_T1;
            end
            ST_T1:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MS_T1;
                if (status.mul_done)
                    state_next = ST_T2;
            end
            ST_T2:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MS_T2;
                if (status.mul_done)
                    state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.op     = OP_NUM;
                state_next = status.den_zero ? ST_ZD : ST_DIVM;
            end
            ST_ZD:
            begin
                cmd.op     = OP_ZERO_DEN;
                state_next = ret_state;
            end
            ST_DIVM:
            begin
                cmd.op = OP_DIV_MEAN;
                if (status.div_done)
                    state_next = ST_MFIX;
            end
            ST_MFIX:
            begin
                cmd.op     = OP_MEAN_FIX;
                state_next = ST_VMUL;
            end
            ST_VMUL:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MS_VNUM;
                if (status.mul_done)
                    state_next = ST_DIVV;
            end
            ST_DIVV:
            begin
                cmd.op = OP_DIV_VAR;
                if (status.div_done)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (status.sqrt_done)
                    state_next = ST_SDFIX;
            end
            ST_SDFIX:
            begin
                cmd.op     = OP_SD_FIX;
                state_next = ret_state;
            end
            ST_DMUL:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MS_DRAW;
                if (status.mul_done)
                    state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                cmd.op     = OP_DRAW;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.op           = OP_ACCUM;
                after_start_next = 1'b0;
                state_next       = ST_NN2;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_OUT)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/nppr_datapath.sv]
module nppr_datapath #(
    parameter int FRAC_BITS = nppr_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nppr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nppr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic signed [31:0]            normal_deviate,
    input  nppr_pkg::dp_cmd_t             cmd,
    output nppr_pkg::dp_status_t          status,
    output logic signed [31:0]            mean_before,
    output logic signed [31:0]            drawn_value,
    output logic signed [31:0]            posterior_mean,
    output logic [30:0]                   predictive_sd,
    output logic                          saturated
);
    import nppr_pkg::*;

    localparam logic signed [63:0] I32MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32MIN = -64'sd2147483648;
    localparam logic [63:0]        SDMAX  = 64'd2147483647;

    // configuration
    logic [30:0]        noise_sd_reg, prior_sd_reg;
    logic signed [31:0] prior_mean_reg;
    logic signed [47:0] obs_sum_reg;
    logic [23:0]        obs_count_reg;

    // architectural state
    logic signed [47:0] run_sum_reg;
    logic [23:0]        count_reg;
    logic signed [31:0] cur_mean_reg;
    logic [30:0]        cur_sd_reg;
    logic               sat_reg;
    logic signed [31:0] z_reg;

    // intermediates
    logic [63:0]        nn2_reg, pp2_reg;
    logic [127:0]       den_reg, num_reg, t2_reg;
    logic signed [63:0] shifted_reg, drawn_reg;
    logic signed [31:0] mean_before_reg;

    // multiplier
    logic [63:0]  mul_a_reg, mul_b_reg, mul_a, mul_b;
    logic [127:0] acc_reg, pp_wide, mul_res;
    logic [63:0]  pp;
    logic [1:0]   mul_cnt_reg;
    logic         mul_run_reg, mul_fin_reg, mul_neg_reg, mul_neg;
    logic [63:0]  pm_mag, rs_mag, z_mag;
    logic signed [63:0] pm64, rs64, z64;

    // divider
    logic [127:0] dvd_reg, rem_reg, quo_reg, div_trial;
    logic [6:0]   div_cnt_reg;
    logic         div_run_reg, div_fin_reg, div_ge;

    // square root
    logic [63:0] sq_v_reg, sq_res_reg, sq_bit_reg, sq_trial;
    logic [4:0]  sq_cnt_reg;
    logic        sq_run_reg, sq_fin_reg;

    logic               mean_neg, mean_over;
    logic signed [63:0] drawn_raw, prod_s;
    logic signed [48:0] sum_raw;

    // output registers
    logic signed [31:0] out_mb_reg, out_dv_reg, out_pm_reg;
    logic [30:0]        out_sd_reg;
    logic               out_sat_reg;

    assign pm64   = 64'(prior_mean_reg);
    assign rs64   = 64'(run_sum_reg);
    assign z64    = 64'(z_reg);
    assign pm_mag = pm64[63] ? -pm64 : pm64;
    assign rs_mag = rs64[63] ? -rs64 : rs64;
    assign z_mag  = z64[63] ? -z64 : z64;

    always_comb
    begin
        mul_a   = 64'd0;
        mul_b   = 64'd0;
        mul_neg = 1'b0;
        unique case (cmd.sel)
            MS_NN2:
            begin
                mul_a = 64'(noise_sd_reg);
                mul_b = 64'(noise_sd_reg);
            end
            MS_PP2:
            begin
                mul_a = 64'(prior_sd_reg);
                mul_b = 64'(prior_sd_reg);
            end
            MS_DEN:
            begin
                mul_a = 64'(count_reg);
                mul_b = pp2_reg;
            end
            MS_T1:
            begin
                mul_a   = pm_mag;
                mul_b   = nn2_reg;
                mul_neg = prior_mean_reg[31];
            end
            MS_T2:
            begin
                mul_a   = rs_mag;
                mul_b   = pp2_reg;
                mul_neg = run_sum_reg[47];
            end
            MS_VNUM:
            begin
                mul_a = pp2_reg;
                mul_b = nn2_reg;
            end
            MS_DRAW:
            begin
                mul_a   = z_mag;
                mul_b   = 64'(cur_sd_reg);
                mul_neg = z_reg[31];
            end
            default:
            begin
                mul_a = 64'd0;
            end
        endcase
    end

    // Partial products: low x low, low x high, high x low, high x high.
    assign pp = (mul_cnt_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0])
              * (mul_cnt_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0]);

    always_comb
    begin
        case (mul_cnt_reg)
            2'd0:    pp_wide = {64'd0, pp};
            2'd3:    pp_wide = {pp, 64'd0};
            default: pp_wide = {32'd0, pp, 32'd0};
        endcase
    end

    assign mul_res = mul_neg_reg ? -acc_reg : acc_reg;
    assign prod_s  = $signed(mul_res[63:0]);

    assign div_trial = {rem_reg[126:0], dvd_reg[127]};
    assign div_ge    = (div_trial >= den_reg);
    assign sq_trial  = sq_res_reg + sq_bit_reg;

    assign mean_neg  = num_reg[127];
    assign mean_over = (quo_reg[127:64] != 64'd0)
                     || (quo_reg[63:0] > (mean_neg ? 64'h8000_0000 : 64'h7FFF_FFFF));
    assign drawn_raw = 64'(cur_mean_reg) + shifted_reg;
    assign sum_raw   = 49'(run_sum_reg) + 49'(drawn_reg);

    // multiplier, divider and root sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_run_reg <= 1'b0;
            mul_fin_reg <= 1'b0;
            mul_cnt_reg <= 2'd0;
            div_run_reg <= 1'b0;
            div_fin_reg <= 1'b0;
            div_cnt_reg <= 7'd0;
            sq_run_reg  <= 1'b0;
            sq_fin_reg  <= 1'b0;
            sq_cnt_reg  <= 5'd0;
        end
        else
        begin
            mul_fin_reg <= 1'b0;
            if (cmd.op == OP_MUL && !mul_run_reg && !mul_fin_reg)
            begin
                mul_run_reg <= 1'b1;
                mul_cnt_reg <= 2'd0;
            end
            else if (mul_run_reg)
            begin
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3)
                begin
                    mul_run_reg <= 1'b0;
                    mul_fin_reg <= 1'b1;
                end
            end

            div_fin_reg <= 1'b0;
            if ((cmd.op == OP_DIV_MEAN || cmd.op == OP_DIV_VAR)
                && !div_run_reg && !div_fin_reg)
            begin
                div_run_reg <= 1'b1;
                div_cnt_reg <= 7'd0;
            end
            else if (div_run_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 7'd1;
                if (div_cnt_reg == 7'd127)
                begin
                    div_run_reg <= 1'b0;
                    div_fin_reg <= 1'b1;
                end
            end

            sq_fin_reg <= 1'b0;
            if (cmd.op == OP_SQRT && !sq_run_reg && !sq_fin_reg)
            begin
                sq_run_reg <= 1'b1;
                sq_cnt_reg <= 5'd0;
            end
            else if (sq_run_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'd31)
                begin
                    sq_run_reg <= 1'b0;
                    sq_fin_reg <= 1'b1;
                end
            end
        end
    end

    // arithmetic working registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MUL && !mul_run_reg && !mul_fin_reg)
        begin
            mul_a_reg   <= mul_a;
            mul_b_reg   <= mul_b;
            mul_neg_reg <= mul_neg;
            acc_reg     <= 128'd0;
        end
        else if (mul_run_reg)
        begin
            acc_reg <= acc_reg + pp_wide;
        end

        if (mul_fin_reg)
        begin
            unique case (cmd.sel)
                MS_NN2:  nn2_reg     <= acc_reg[63:0];
                MS_PP2:  pp2_reg     <= acc_reg[63:0];
                MS_DEN:  den_reg     <= acc_reg + {64'd0, nn2_reg};
                MS_T1:   num_reg     <= mul_res;
                MS_T2:   t2_reg      <= mul_res;
                MS_DRAW: shifted_reg <= prod_s >>> FRAC_BITS;
                default: ;
            endcase
        end
        if (cmd.op == OP_NUM)
            num_reg <= num_reg + t2_reg;

        if (cmd.op == OP_DIV_MEAN && !div_run_reg && !div_fin_reg)
        begin
            dvd_reg <= mean_neg ? -num_reg : num_reg;
            rem_reg <= 128'd0;
            quo_reg <= 128'd0;
        end
        else if (cmd.op == OP_DIV_VAR && !div_run_reg && !div_fin_reg)
        begin
            dvd_reg <= acc_reg;
            rem_reg <= 128'd0;
            quo_reg <= 128'd0;
        end
        else if (div_run_reg)
        begin
            rem_reg <= div_ge ? div_trial - den_reg : div_trial;
            quo_reg <= {quo_reg[126:0], div_ge};
            dvd_reg <= {dvd_reg[126:0], 1'b0};
        end

        // Starting from the top bit pair and running all steps gives the floored root.
        if (cmd.op == OP_SQRT && !sq_run_reg && !sq_fin_reg)
        begin
            sq_v_reg   <= nn2_reg + quo_reg[63:0];
            sq_res_reg <= 64'd0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (sq_run_reg)
        begin
            if (sq_v_reg >= sq_trial)
            begin
                sq_v_reg   <= sq_v_reg - sq_trial;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end

        if (cmd.op == OP_ACCEPT)
            z_reg <= normal_deviate;

        if (cmd.op == OP_DRAW)
        begin
            mean_before_reg <= cur_mean_reg;
            if (drawn_raw > I32MAX)
                drawn_reg <= I32MAX;
            else if (drawn_raw < I32MIN)
                drawn_reg <= I32MIN;
            else
                drawn_reg <= drawn_raw;
        end

        if (cmd.op == OP_OUT)
        begin
            out_mb_reg  <= mean_before_reg;
            out_dv_reg  <= drawn_reg[31:0];
            out_pm_reg  <= cur_mean_reg;
            out_sd_reg  <= cur_sd_reg;
            out_sat_reg <= sat_reg;
        end
    end

    // configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_sd_reg   <= 31'(64'd1 << FRAC_BITS);
            prior_sd_reg   <= 31'(64'd1 << FRAC_BITS);
            prior_mean_reg <= 32'sd0;
            obs_sum_reg    <= 48'sd0;
            obs_count_reg  <= 24'd0;
            run_sum_reg    <= 48'sd0;
            count_reg      <= 24'd0;
            cur_mean_reg   <= 32'sd0;
            cur_sd_reg     <= 31'd0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_NOISE_SD:   noise_sd_reg   <= cfg_data[30:0];
                    CFG_PRIOR_MEAN: prior_mean_reg <= cfg_data[31:0];
                    CFG_PRIOR_SD:   prior_sd_reg   <= cfg_data[30:0];
                    CFG_OBS_SUM:    obs_sum_reg    <= cfg_data[47:0];
                    CFG_OBS_COUNT:  obs_count_reg  <= cfg_data[23:0];
                    default: ;
                endcase
            end

            unique case (cmd.op)
                OP_ACCEPT:
                begin
                    sat_reg <= 1'b0;
                end
                OP_LOAD:
                begin
                    run_sum_reg <= obs_sum_reg;
                    count_reg   <= obs_count_reg;
                end
                OP_ZERO_DEN:
                begin
                    cur_mean_reg <= mean_neg ? I32MIN[31:0] : I32MAX[31:0];
                    cur_sd_reg   <= SDMAX[30:0];
                    sat_reg      <= 1'b1;
                end
                OP_MEAN_FIX:
                begin
                    if (mean_over)
                    begin
                        cur_mean_reg <= mean_neg ? I32MIN[31:0] : I32MAX[31:0];
                        sat_reg      <= 1'b1;
                    end
                    else
                    begin
                        cur_mean_reg <= mean_neg ? -quo_reg[31:0] : quo_reg[31:0];
                    end
                end
                OP_SD_FIX:
                begin
                    if (sq_res_reg > SDMAX)
                    begin
                        cur_sd_reg <= SDMAX[30:0];
                        sat_reg    <= 1'b1;
                    end
                    else
                    begin
                        cur_sd_reg <= sq_res_reg[30:0];
                    end
                end
                OP_DRAW:
                begin
                    if (drawn_raw > I32MAX || drawn_raw < I32MIN)
                        sat_reg <= 1'b1;
                end
                OP_ACCUM:
                begin
                    // A carry into the extra bit that disagrees with the sign means overflow.
                    if (sum_raw[48] != sum_raw[47])
                    begin
                        run_sum_reg <= sum_raw[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                        sat_reg     <= 1'b1;
                    end
                    else
                    begin
                        run_sum_reg <= sum_raw[47:0];
                    end
                    if (count_reg == {24{1'b1}})
                        sat_reg <= 1'b1;
                    else
                        count_reg <= count_reg + 24'd1;
                end
                default: ;
            endcase
        end
    end

    assign status.mul_done  = mul_fin_reg;
    assign status.div_done  = div_fin_reg;
    assign status.sqrt_done = sq_fin_reg;
    assign status.den_zero  = (den_reg == 128'd0);

    assign mean_before    = out_mb_reg;
    assign drawn_value    = out_dv_reg;
    assign posterior_mean = out_pm_reg;
    assign predictive_sd  = out_sd_reg;
    assign saturated      = out_sat_reg;

endmodule

[rtl/normal_posterior_predictive_resampler.sv]
// An accepted item is done once its result is in the output register; start_chain adds
// a second posterior update. The input reopens only after that, so one item at a time;
// a result held by out_stall delays the next one until it is taken.
// The time taken is set by the bit-serial divider, two 128-step divisions per posterior
// update, plus a 32-step square root and a four-pass 32x32 multiplier.
// Reset (asynchronous, active low) clears control, state and configuration to defaults.
module normal_posterior_predictive_resampler #(
    parameter int FRAC_BITS = nppr_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nppr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nppr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            start_chain,
    input  logic signed [31:0]              normal_deviate,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              mean_before,
    output logic signed [31:0]              drawn_value,
    output logic signed [31:0]              posterior_mean,
    output logic [30:0]                     predictive_sd,
    output logic                            saturated
);
    import nppr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    nppr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .start_chain (start_chain),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status)
    );

    nppr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .normal_deviate (normal_deviate),
        .cmd            (cmd),
        .status         (status),
        .mean_before    (mean_before),
        .drawn_value    (drawn_value),
        .posterior_mean (posterior_mean),
        .predictive_sd  (predictive_sd),
        .saturated      (saturated)
    );

    // A new result is never written over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> !(out_valid && out_stall))
        else $error("result overwritten while stalled");

    // The multiplier only finishes while the controller waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> (cmd.op == OP_MUL))
        else $error("multiplier done outside a multiply step");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (cmd.op == OP_DIV_MEAN || cmd.op == OP_DIV_VAR))
        else $error("divider done outside a divide step");

    // One item at a time: an accepted item closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted while busy");

endmodule
